// ===== hdl/citl_pkg.sv =====
`timescale 1ns / 1ps

package citl_pkg;

    // Width of the divisor and class registers and of the APB data bus.
    localparam int CFG_BITS  = 32;
    localparam int LIM_BITS  = 8;
    localparam int ROT_BITS  = 16;
    localparam int ADDR_BITS = 4;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_DIVISOR = 2'd0,
        REG_CLASS   = 2'd1,
        REG_RETRY   = 2'd2,
        REG_NONE    = 2'd3
    } reg_idx_t;

    // Frame kind carried in tuser.
    typedef enum logic {
        CMD_ACQUIRE = 1'b0,
        CMD_TRACK   = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_SQ,
        ST_ACC,
        ST_UPDATE,
        ST_FIN
    } state_t;

endpackage

// ===== hdl/closest_id_target_lock_tracker_top.sv =====
`timescale 1ns / 1ps

// Channel      Dir  Contents
// s_* stream   in   tdata: det_id, det_x, det_y, det_z, det_qx, det_qy, det_qz, det_qw;
//                   tuser: cmd, present; tlast: frame_end
// m_* stream   out  tdata: out_id, out_x, out_y, out_z, out_qx, out_qy, out_qz, out_qw;
//                   tuser: out_ok, out_locked, out_coasting
// APB          in   id_divisor at 0x0, id_class at 0x4, retry_limit at 0x8
//
// An acquire transaction that carries a detection runs through the divider and the
// squaring unit: the restoring divider computes the id remainder one bit per cycle, and
// the one shared squaring multiplier then runs three times, each product registered before
// it is added to the norm. Acquire detections outside the id class skip the squaring, and
// track or empty transactions go straight to the check state; a transaction that closes a
// frame then passes through the frame end state.
// s_tready is high only while the sequencer is idle; one transaction is worked at a time.
// A frame result sits in the output register while the next transaction is accepted; the
// sequencer stalls at the end of the next frame only if that result is still not taken.
// Reset is asynchronous and active low; it drops the lock and clears the sequencer and frame control state.
// No memory is used, so the block is ready right after reset.

module closest_id_target_lock_tracker_top #(
    parameter int POS_BITS   = 24,
    parameter int ID_BITS    = 32,
    parameter int RETRY_BITS = 8
) (
    input  logic clk,
    input  logic rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // det_id, det_x, det_y, det_z, det_qx, det_qy, det_qz, det_qw, zero fill
    input  logic [((ID_BITS + 3 * POS_BITS + 4 * citl_pkg::ROT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // cmd, present
    input  logic [1:0]                      s_tuser,
    input  logic                            s_tlast,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_id, out_x, out_y, out_z, out_qx, out_qy, out_qz, out_qw, zero fill
    output logic [((ID_BITS + 3 * POS_BITS + 4 * citl_pkg::ROT_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // out_ok, out_locked, out_coasting
    output logic [2:0]                      m_tuser,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [citl_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [citl_pkg::CFG_BITS-1:0]   pwdata,
    output logic [citl_pkg::CFG_BITS-1:0]   prdata,
    output logic                            pready
);

    localparam int ROT_BITS  = citl_pkg::ROT_BITS;
    localparam int CFG_BITS  = citl_pkg::CFG_BITS;
    localparam int LIM_BITS  = citl_pkg::LIM_BITS;
    localparam int FIELD_W   = ID_BITS + 3 * POS_BITS + 4 * ROT_BITS;
    localparam int TDATA_W   = ((FIELD_W + 7) / 8) * 8;
    localparam int NORM_W    = 2 * POS_BITS;
    localparam int CNT_W     = $clog2(ID_BITS);
    localparam int CMP_W     = CFG_BITS + 1;

    // Configuration registers.
    logic [CFG_BITS-1:0] id_divisor_reg;
    logic [CFG_BITS-1:0] id_class_reg;
    logic [LIM_BITS-1:0] retry_limit_reg;

    // Sequencer.
    citl_pkg::state_t state_reg, state_next;
    logic             accept;
    logic             fin_go;
    logic             div_done;
    logic             sq_last;

    // Item held while it is worked.
    logic                       cmd_reg;
    logic                       present_reg;
    logic                       last_reg;
    logic [ID_BITS-1:0]         id_reg;
    logic signed [POS_BITS-1:0] pos_reg [3];
    logic signed [ROT_BITS-1:0] rot_reg [4];

    // Shared divider and squaring unit.
    logic [ID_BITS-1:0]         div_sh_reg;
    logic [ID_BITS-1:0]         rem_reg;
    logic [CNT_W-1:0]           div_cnt_reg;
    logic [CMP_W-1:0]           trial;
    logic [CMP_W-1:0]           trial_diff;
    logic                       trial_ge;
    logic [1:0]                 sq_idx_reg;
    logic signed [POS_BITS-1:0] mul_a;
    logic signed [NORM_W-1:0]   prod_full;
    logic [NORM_W-1:0]          prod_reg;
    logic [NORM_W-1:0]          norm_reg;
    logic                       class_hit;

    // Frame state.
    logic                       lock_flag_reg;
    logic [ID_BITS-1:0]         locked_target_reg;
    logic [RETRY_BITS-1:0]      miss_count_reg;
    logic [ID_BITS-1:0]         held_id_reg;
    logic signed [POS_BITS-1:0] held_pos_reg [3];
    logic signed [ROT_BITS-1:0] held_rot_reg [4];
    logic                       cand_found_reg;
    logic [NORM_W-1:0]          cand_norm_reg;
    logic [ID_BITS-1:0]         cand_id_reg;
    logic signed [POS_BITS-1:0] cand_pos_reg [3];
    logic signed [ROT_BITS-1:0] cand_rot_reg [4];

    // Frame end decisions.
    logic [RETRY_BITS+LIM_BITS-1:0] lim_ext;
    logic [RETRY_BITS-1:0]          lim;
    logic                           is_acq;
    logic                           take_hold;
    logic                           coast;
    logic                           drop;
    logic                           res_ok;
    logic                           lock_next;

    // Output register.
    logic                       m_tvalid_reg;
    logic [2:0]                 m_tuser_reg;
    logic [ID_BITS-1:0]         out_id_reg;
    logic signed [POS_BITS-1:0] out_pos_reg [3];
    logic signed [ROT_BITS-1:0] out_rot_reg [4];

    // ------------------------------------------------------------------
    // APB configuration port. Writes complete in the access cycle.
    // ------------------------------------------------------------------
    citl_pkg::reg_idx_t cfg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = citl_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_divisor_reg  <= CFG_BITS'(1);
            id_class_reg    <= '0;
            retry_limit_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                citl_pkg::REG_DIVISOR: id_divisor_reg  <= pwdata;
                citl_pkg::REG_CLASS:   id_class_reg    <= pwdata;
                citl_pkg::REG_RETRY:   retry_limit_reg <= pwdata[LIM_BITS-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            citl_pkg::REG_DIVISOR: prdata = id_divisor_reg;
            citl_pkg::REG_CLASS:   prdata = id_class_reg;
            citl_pkg::REG_RETRY:   prdata = CFG_BITS'(retry_limit_reg);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            citl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[1] && (s_tuser[0] == citl_pkg::CMD_ACQUIRE))
                        state_next = citl_pkg::ST_DIV;
                    else
                        state_next = citl_pkg::ST_CHECK;
                end
            end
            citl_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = citl_pkg::ST_CHECK;
            end
            citl_pkg::ST_CHECK:
            begin
                if (class_hit)
                    state_next = citl_pkg::ST_SQ;
                else if (last_reg)
                    state_next = citl_pkg::ST_FIN;
                else
                    state_next = citl_pkg::ST_IDLE;
            end
            citl_pkg::ST_SQ:
                state_next = citl_pkg::ST_ACC;
            citl_pkg::ST_ACC:
            begin
                if (sq_last)
                    state_next = citl_pkg::ST_UPDATE;
                else
                    state_next = citl_pkg::ST_SQ;
            end
            citl_pkg::ST_UPDATE:
            begin
                if (last_reg)
                    state_next = citl_pkg::ST_FIN;
                else
                    state_next = citl_pkg::ST_IDLE;
            end
            citl_pkg::ST_FIN:
            begin
                if (fin_go)
                    state_next = citl_pkg::ST_IDLE;
            end
            default:
                state_next = citl_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: control outputs.
    always_comb
    begin
        s_tready = (state_reg == citl_pkg::ST_IDLE);
        fin_go   = (state_reg == citl_pkg::ST_FIN) && (!m_tvalid_reg || m_tready);
        div_done = (div_cnt_reg == CNT_W'(ID_BITS - 1));
        sq_last  = (sq_idx_reg == 2'd2);
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= citl_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Item capture.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= s_tuser[0];
            present_reg <= s_tuser[1];
            last_reg    <= s_tlast;
            id_reg      <= s_tdata[ID_BITS-1:0];
            for (int i = 0; i < 3; i++)
                pos_reg[i] <= s_tdata[ID_BITS + i * POS_BITS +: POS_BITS];
            for (int i = 0; i < 4; i++)
                rot_reg[i] <= s_tdata[ID_BITS + 3 * POS_BITS + i * ROT_BITS +: ROT_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider for the id remainder, one quotient bit per cycle.
    // A zero divisor subtracts nothing, which leaves the id itself.
    // ------------------------------------------------------------------
    assign trial      = CMP_W'({rem_reg, div_sh_reg[ID_BITS-1]});
    assign trial_ge   = (trial >= CMP_W'(id_divisor_reg));
    assign trial_diff = trial - CMP_W'(id_divisor_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            div_sh_reg  <= s_tdata[ID_BITS-1:0];
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (state_reg == citl_pkg::ST_DIV)
        begin
            div_sh_reg  <= {div_sh_reg[ID_BITS-2:0], 1'b0};
            rem_reg     <= trial_ge ? trial_diff[ID_BITS-1:0] : trial[ID_BITS-1:0];
            div_cnt_reg <= div_cnt_reg + CNT_W'(1);
        end
    end

    assign class_hit = present_reg && (cmd_reg == citl_pkg::CMD_ACQUIRE)
                       && (CFG_BITS'(rem_reg) == id_class_reg);

    // ------------------------------------------------------------------
    // Shared squaring unit. The norm of three squares is below 2^(2*POS_BITS),
    // so the accumulator never needs to saturate.
    // ------------------------------------------------------------------
    assign mul_a     = pos_reg[sq_idx_reg];
    assign prod_full = mul_a * mul_a;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_idx_reg <= '0;
            norm_reg   <= '0;
        end
        else if (state_reg == citl_pkg::ST_SQ)
        begin
            prod_reg <= prod_full;
        end
        else if (state_reg == citl_pkg::ST_ACC)
        begin
            norm_reg   <= norm_reg + prod_reg;
            sq_idx_reg <= sq_idx_reg + 2'd1;
        end
    end

    // ------------------------------------------------------------------
    // Frame end decisions.
    // ------------------------------------------------------------------
    assign lim_ext   = {{RETRY_BITS{1'b0}}, retry_limit_reg};
    assign lim       = lim_ext[RETRY_BITS-1:0];
    assign is_acq    = (cmd_reg == citl_pkg::CMD_ACQUIRE);
    assign take_hold = cand_found_reg && (is_acq || lock_flag_reg);
    assign coast     = !is_acq && lock_flag_reg && !cand_found_reg && (miss_count_reg < lim);
    assign drop      = !is_acq && lock_flag_reg && !cand_found_reg && !(miss_count_reg < lim);
    assign res_ok    = take_hold || coast;
    assign lock_next = is_acq ? (lock_flag_reg || cand_found_reg) : (lock_flag_reg && !drop);

    // Candidate of the current frame and the lock state. The locked id starts at zero,
    // so a track detection with id zero matches even before the first lock.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_found_reg    <= 1'b0;
            lock_flag_reg     <= 1'b0;
            miss_count_reg    <= '0;
            locked_target_reg <= '0;
        end
        else if (fin_go)
        begin
            cand_found_reg <= 1'b0;
            lock_flag_reg  <= lock_next;
            if (is_acq && cand_found_reg)
                locked_target_reg <= cand_id_reg;
            if (take_hold)
                miss_count_reg <= '0;
            else if (coast)
                miss_count_reg <= miss_count_reg + RETRY_BITS'(1);
        end
        else if ((state_reg == citl_pkg::ST_CHECK) && present_reg && !cand_found_reg
                 && (cmd_reg == citl_pkg::CMD_TRACK) && (id_reg == locked_target_reg))
        begin
            cand_found_reg <= 1'b1;
        end
        else if (state_reg == citl_pkg::ST_UPDATE)
        begin
            cand_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (((state_reg == citl_pkg::ST_CHECK) && present_reg && !cand_found_reg
             && (cmd_reg == citl_pkg::CMD_TRACK) && (id_reg == locked_target_reg))
            || ((state_reg == citl_pkg::ST_UPDATE)
                && (!cand_found_reg || (norm_reg < cand_norm_reg))))
        begin
            // A track match carries a norm of zero, so no later detection displaces it.
            cand_norm_reg <= (state_reg == citl_pkg::ST_UPDATE) ? norm_reg : '0;
            cand_id_reg   <= id_reg;
            cand_pos_reg  <= pos_reg;
            cand_rot_reg  <= rot_reg;
        end
        if (fin_go && take_hold)
        begin
            held_id_reg  <= cand_id_reg;
            held_pos_reg <= cand_pos_reg;
            held_rot_reg <= cand_rot_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register. Fields read as zero whenever no vector is reported.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (fin_go)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            m_tuser_reg <= {coast, lock_next, res_ok};
            if (!res_ok)
            begin
                out_id_reg <= '0;
                for (int i = 0; i < 3; i++)
                    out_pos_reg[i] <= '0;
                for (int i = 0; i < 4; i++)
                    out_rot_reg[i] <= '0;
            end
            else if (take_hold)
            begin
                out_id_reg  <= cand_id_reg;
                out_pos_reg <= cand_pos_reg;
                out_rot_reg <= cand_rot_reg;
            end
            else
            begin
                out_id_reg  <= held_id_reg;
                out_pos_reg <= held_pos_reg;
                out_rot_reg <= held_rot_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = TDATA_W'({out_rot_reg[3], out_rot_reg[2], out_rot_reg[1], out_rot_reg[0],
                                out_pos_reg[2], out_pos_reg[1], out_pos_reg[0], out_id_reg});

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_coast_implies_lock: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[0] && m_tuser[1])
        else $error("coasting result without a valid locked vector");

    a_no_vector_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[2])
        else $error("result without a vector carries nonzero fields");

    a_div_progress: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == citl_pkg::ST_DIV |=>
            state_reg == citl_pkg::ST_DIV || state_reg == citl_pkg::ST_CHECK)
        else $error("divider left before the remainder was complete");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == citl_pkg::ST_FIN) && $past(last_reg))
        else $error("result produced outside a frame end");

    a_cand_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> !cand_found_reg && state_reg == citl_pkg::ST_IDLE)
        else $error("candidate survived the end of its frame");

endmodule
